FILE: rtl/ppts_pkg.sv
// Shared types, codes and defaults for the periodic priority task scheduler.
// Used by ppts_cell, the top level and ppts_checker; depends on nothing.
package ppts_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int NUM_EVENTS_DEF  = 2;
    localparam int COUNT_WIDTH_DEF = 16;

    // widest slot index and counter over the supported parameter range
    localparam int IDX_W     = 5;
    localparam int CNT_W_MAX = 32;

    localparam logic [2:0] KIND_TICK         = 3'd0;
    localparam logic [2:0] KIND_EVENT        = 3'd1;
    localparam logic [2:0] KIND_STOP         = 3'd2;
    localparam logic [2:0] KIND_ADD_PERIODIC = 3'd3;
    localparam logic [2:0] KIND_ADD_EVENT    = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic        event_id;
        logic [15:0] task_period;
        logic [7:0]  task_priority;
        logic [31:0] task_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  run_slot;
        logic [31:0] run_address;
        logic        switched;
        logic [2:0]  added_slot;
        logic        table_full;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_FREE,
        ST_STOPPED,
        ST_SUSPENDED,
        ST_RUNNING
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_WAKE,
        OP_STOP,
        OP_ADD,
        OP_SWITCH
    } t_cmd_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd_op                op;
        logic [IDX_W-1:0]       idx_a;
        logic [IDX_W-1:0]       idx_b;
        logic                   add_event;
        logic [CNT_W_MAX-1:0]   period;
        logic [7:0]             priority_val;
        logic [31:0]            address;
    } t_cmd;

    typedef struct packed {
        logic             valid;
        logic             has_best;
        logic [7:0]       best_pri;
        logic [IDX_W-1:0] best_idx;
        logic             has_free;
        logic [IDX_W-1:0] free_idx;
    } t_scan;

endpackage

FILE: rtl/ppts_cell.sv
// One slot of the scheduler table: status, counter, period, priority, address.
// Folds its slot into the registered scan carry passed to the next cell; uses ppts_pkg.
module ppts_cell #(
    parameter int CELL_IDX    = 0,
    parameter int COUNT_WIDTH = ppts_pkg::COUNT_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppts_pkg::t_cmd  i_cmd,
    input  ppts_pkg::t_scan i_scan,
    output ppts_pkg::t_scan o_scan,
    output logic [31:0]     o_address
);

    ppts_pkg::t_status       r_status,   n_status;
    logic [COUNT_WIDTH-1:0]  r_count,    n_count;
    logic [COUNT_WIDTH-1:0]  r_period,   n_period;
    logic [7:0]              r_priority, n_priority;
    logic [31:0]             r_address,  n_address;
    ppts_pkg::t_scan         r_scan,     n_scan;

    logic                    w_sel_a;
    logic                    w_sel_b;
    logic                    w_active;
    logic [COUNT_WIDTH-1:0]  w_count_inc;

    assign w_sel_a     = (i_cmd.idx_a == ppts_pkg::IDX_W'(CELL_IDX));
    assign w_sel_b     = (i_cmd.idx_b == ppts_pkg::IDX_W'(CELL_IDX));
    assign w_count_inc = r_count + COUNT_WIDTH'(1);
    assign w_active    = (r_status == ppts_pkg::ST_SUSPENDED) ||
                         (r_status == ppts_pkg::ST_RUNNING);

    always_comb begin
        n_status   = r_status;
        n_count    = r_count;
        n_period   = r_period;
        n_priority = r_priority;
        n_address  = r_address;
        unique case (i_cmd.op)
            ppts_pkg::OP_TICK: begin
                if (r_period != '0) begin
                    n_count = (w_count_inc == r_period) ? '0 : w_count_inc;
                end
                if (n_count == '0 && r_status == ppts_pkg::ST_STOPPED) begin
                    n_status = ppts_pkg::ST_SUSPENDED;
                end
            end
            ppts_pkg::OP_WAKE: begin
                if (w_sel_a) begin
                    n_status = ppts_pkg::ST_SUSPENDED;
                end
            end
            ppts_pkg::OP_STOP: begin
                if (w_sel_a) begin
                    n_status = ppts_pkg::ST_STOPPED;
                end
            end
            ppts_pkg::OP_ADD: begin
                if (w_sel_a) begin
                    n_status   = ppts_pkg::ST_STOPPED;
                    n_address  = i_cmd.address;
                    n_priority = i_cmd.priority_val;
                    if (i_cmd.add_event) begin
                        n_period = '0;
                        n_count  = COUNT_WIDTH'(1);
                    end else begin
                        n_period = i_cmd.period[COUNT_WIDTH-1:0];
                        n_count  = '0;
                    end
                end
            end
            ppts_pkg::OP_SWITCH: begin
                if (w_sel_a) begin
                    n_status = ppts_pkg::ST_RUNNING;
                end else if (w_sel_b && r_status == ppts_pkg::ST_RUNNING) begin
                    n_status = ppts_pkg::ST_SUSPENDED;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_scan = i_scan;
        if (w_active && (!i_scan.has_best || r_priority > i_scan.best_pri)) begin
            n_scan.has_best = 1'b1;
            n_scan.best_pri = r_priority;
            n_scan.best_idx = ppts_pkg::IDX_W'(CELL_IDX);
        end
        if (!i_scan.has_free && r_status == ppts_pkg::ST_FREE) begin
            n_scan.has_free = 1'b1;
            n_scan.free_idx = ppts_pkg::IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= (CELL_IDX == 0) ? ppts_pkg::ST_RUNNING : ppts_pkg::ST_FREE;
            r_count    <= '0;
            r_period   <= COUNT_WIDTH'(1);
            r_priority <= '0;
            r_scan     <= '0;
        end else begin
            r_status   <= n_status;
            r_count    <= n_count;
            r_period   <= n_period;
            r_priority <= n_priority;
            r_scan     <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_address <= n_address;
    end

    assign o_scan    = r_scan;
    assign o_address = r_address;

endmodule

FILE: rtl/periodic_priority_task_scheduler.sv
// Top level of the periodic priority task scheduler: control, event map, output register.
// Instantiates a row of ppts_cell; uses ppts_pkg.
//
//   channel   direction  handshake                    payload
//   input     in         i_in_valid / o_in_stall      i_in_data  (t_in_item)
//   output    out        o_out_valid / i_out_stall    o_out_data (t_out_item)
//   config    in         i_cfg_wr_en                  i_cfg_wr_data (idle address)
//
// No new item is taken before the last one is done: the idle state takes the item, the scan
// state walks the pick and free search down the cell row and captures it, then the done state
// applies the switch or add and loads the result once the output register is free.
// An item is taken while a finished result still waits in the output register.
// Synchronous active-low reset; slot 0 comes out running with all other slots free.
module periodic_priority_task_scheduler #(
    parameter int NUM_SLOTS   = ppts_pkg::NUM_SLOTS_DEF,
    parameter int NUM_EVENTS  = ppts_pkg::NUM_EVENTS_DEF,
    parameter int COUNT_WIDTH = ppts_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ppts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ppts_pkg::t_out_item o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;

    ppts_pkg::t_state    r_state, n_state;
    ppts_pkg::t_in_item  r_item;
    ppts_pkg::t_scan     r_scan;
    ppts_pkg::t_out_item r_out, n_out;
    logic                r_out_valid;
    logic                r_start;
    logic [SW-1:0]       r_current;
    logic [31:0]         r_idle_address;
    logic                r_ev_valid [NUM_EVENTS];
    logic [SW-1:0]       r_ev_slot  [NUM_EVENTS];

    ppts_pkg::t_scan     w_chain [NUM_SLOTS+1];
    logic [31:0]         w_addr  [NUM_SLOTS];
    ppts_pkg::t_cmd      w_cmd;
    logic                w_take;
    logic                w_done;
    logic                w_out_free;
    logic                w_is_tick;
    logic                w_is_add;
    logic                w_switch;
    logic [SW-1:0]       w_best;
    logic [SW-1:0]       w_free;
    logic [SW-1:0]       w_new_cur;
    logic [EW-1:0]       w_in_ev;
    logic [EW-1:0]       w_item_ev;
    logic                w_in_ev_ok;
    logic                w_item_ev_ok;

    assign w_take       = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_is_tick    = (r_item.kind == ppts_pkg::KIND_TICK);
    assign w_is_add     = (r_item.kind == ppts_pkg::KIND_ADD_PERIODIC) ||
                          (r_item.kind == ppts_pkg::KIND_ADD_EVENT);
    assign w_best       = r_scan.best_idx[SW-1:0];
    assign w_free       = r_scan.free_idx[SW-1:0];
    assign w_switch     = w_is_tick && (w_best != r_current);
    assign w_new_cur    = w_switch ? w_best : r_current;
    assign w_in_ev      = EW'(i_in_data.event_id);
    assign w_item_ev    = EW'(r_item.event_id);
    assign w_in_ev_ok   = (int'(i_in_data.event_id) < NUM_EVENTS);
    assign w_item_ev_ok = (int'(r_item.event_id) < NUM_EVENTS);

    always_comb begin
        w_chain[0]          = '0;
        w_chain[0].valid    = r_start;
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        ppts_cell #(
            .CELL_IDX    (g),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_scan    (w_chain[g]),
            .o_scan    (w_chain[g+1]),
            .o_address (w_addr[g])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppts_pkg::S_IDLE: begin
                if (w_take) begin
                    n_state = ppts_pkg::S_SCAN;
                end
            end
            ppts_pkg::S_SCAN: begin
                if (w_chain[NUM_SLOTS].valid) begin
                    n_state = ppts_pkg::S_DONE;
                end
            end
            ppts_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = ppts_pkg::S_IDLE;
                end
            end
            default: n_state = ppts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_done     = 1'b0;
        w_cmd      = '0;
        w_cmd.op   = ppts_pkg::OP_NONE;
        unique case (r_state)
            ppts_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    priority if (i_in_data.kind == ppts_pkg::KIND_TICK) begin
                        w_cmd.op = ppts_pkg::OP_TICK;
                    end else if (i_in_data.kind == ppts_pkg::KIND_EVENT) begin
                        if (w_in_ev_ok && r_ev_valid[w_in_ev]) begin
                            w_cmd.op    = ppts_pkg::OP_WAKE;
                            w_cmd.idx_a = ppts_pkg::IDX_W'(r_ev_slot[w_in_ev]);
                        end
                    end else if (i_in_data.kind == ppts_pkg::KIND_STOP) begin
                        if (r_current != '0) begin
                            w_cmd.op    = ppts_pkg::OP_STOP;
                            w_cmd.idx_a = ppts_pkg::IDX_W'(r_current);
                        end
                    end
                end
            end
            ppts_pkg::S_SCAN: begin
            end
            ppts_pkg::S_DONE: begin
                if (w_out_free) begin
                    w_done = 1'b1;
                    priority if (w_switch) begin
                        w_cmd.op    = ppts_pkg::OP_SWITCH;
                        w_cmd.idx_a = ppts_pkg::IDX_W'(w_best);
                        w_cmd.idx_b = ppts_pkg::IDX_W'(r_current);
                    end else if (w_is_add && r_scan.has_free) begin
                        w_cmd.op           = ppts_pkg::OP_ADD;
                        w_cmd.idx_a        = ppts_pkg::IDX_W'(w_free);
                        w_cmd.add_event    = (r_item.kind == ppts_pkg::KIND_ADD_EVENT);
                        w_cmd.period       = ppts_pkg::CNT_W_MAX'(r_item.task_period);
                        w_cmd.priority_val = r_item.task_priority;
                        w_cmd.address      = r_item.task_address;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out             = '0;
        n_out.run_slot    = 3'(w_new_cur);
        n_out.run_address = (w_new_cur == '0) ? r_idle_address : w_addr[w_new_cur];
        n_out.switched    = w_switch;
        if (w_is_add) begin
            n_out.added_slot = r_scan.has_free ? 3'(w_free) : 3'd0;
            n_out.table_full = !r_scan.has_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ppts_pkg::S_IDLE;
            r_start        <= 1'b0;
            r_current      <= '0;
            r_out_valid    <= 1'b0;
            r_idle_address <= '0;
        end else begin
            r_state <= n_state;
            r_start <= w_take;
            if (w_done && w_switch) begin
                r_current <= w_best;
            end
            if (w_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_idle_address <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item <= i_in_data;
        end
        if (w_chain[NUM_SLOTS].valid) begin
            r_scan <= w_chain[NUM_SLOTS];
        end
        if (w_done) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_EVENTS; e++) begin
                r_ev_valid[e] <= 1'b0;
            end
        end else if (w_done && r_item.kind == ppts_pkg::KIND_ADD_EVENT &&
                     r_scan.has_free && w_item_ev_ok) begin
            r_ev_valid[w_item_ev] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && r_item.kind == ppts_pkg::KIND_ADD_EVENT &&
            r_scan.has_free && w_item_ev_ok) begin
            r_ev_slot[w_item_ev] <= w_free;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/ppts_checker.sv
// Port-level checks for the periodic priority task scheduler.
// Uses ppts_pkg; bound to periodic_priority_task_scheduler at the end of this file.
module ppts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input ppts_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the scan finished");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

endmodule

bind periodic_priority_task_scheduler ppts_checker u_ppts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_data    (o_out_data)
);
